// File: rtl/core/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg
// shared codes, constants and types of the cash register reply deframer
// ----------------------------------------------------------------------------
package crd_pkg;

    // framing characters
    localparam logic [7:0] SOH_BYTE   = 8'h01;
    localparam logic [7:0] ETX_BYTE   = 8'h03;
    localparam logic [7:0] EOT_BYTE   = 8'h04;
    localparam logic [7:0] ENQ_BYTE   = 8'h05;
    localparam logic [7:0] LEN_OFFSET = 8'h20;
    localparam logic [3:0] CHAR_BASE  = 4'h3;   // checksum digit is 0x30 + nibble

    // length rules; the *_OFS offsets are relative to the declared length
    localparam logic [7:0] MIN_LENGTH        = 8'd10;
    localparam logic [7:0] MIN_PAYLOAD_LEN   = 8'd11;
    localparam logic [7:0] PAYLOAD_FIRST_IDX = 8'd3;
    localparam logic [7:0] PAYLOAD_LAST_OFS  = 8'd9;
    localparam logic [7:0] EOT_OFS           = 8'd8;
    localparam logic [7:0] STATUS_FIRST_OFS  = 8'd7;
    localparam logic [7:0] STATUS_LAST_OFS   = 8'd2;
    localparam logic [7:0] CSUM_CHARS        = 8'd4;
    localparam logic [7:0] TAIL_DEPTH        = 8'd5;

    localparam int TAIL_N = 5;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_FRAME  = 2'd1,
        ERR_LENGTH = 2'd2,
        ERR_CSUM   = 2'd3
    } err_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // frame state seen by the verdict logic
    typedef struct packed {
        logic                    overflow;
        logic [7:0]              body_count;
        logic [7:0]              declared_length;
        logic [15:0]             sum_excl;     // byte sum without the last four bytes
        logic [TAIL_N-1:0][7:0]  tail;         // tail[0] oldest
        logic [7:0]              eot_byte;
    } crd_judge_t;

    // one result item
    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [1:0]  error_code;
        logic [47:0] status_word;
        logic        is_last;
    } crd_result_t;

endpackage

// File: rtl/core/crd_check.sv
// ----------------------------------------------------------------------------
// crd_check
// end-of-frame verdict from the collected frame state
// ----------------------------------------------------------------------------
module crd_check (
    input  crd_pkg::crd_judge_t judge_i,
    output crd_pkg::err_t       err_o
);
    import crd_pkg::*;

    logic       too_short;
    logic [7:0] count_less_csum;
    logic       len_bad;
    logic       csum_bad;

    always_comb begin
        too_short       = !judge_i.overflow && (judge_i.body_count < TAIL_DEPTH);
        count_less_csum = judge_i.body_count - CSUM_CHARS;
        len_bad         = judge_i.overflow
                        || (count_less_csum != judge_i.declared_length)
                        || (judge_i.declared_length < MIN_LENGTH);
        // four digits, most significant nibble first
        csum_bad = (judge_i.tail[1] != {CHAR_BASE, judge_i.sum_excl[15:12]})
                || (judge_i.tail[2] != {CHAR_BASE, judge_i.sum_excl[11:8]})
                || (judge_i.tail[3] != {CHAR_BASE, judge_i.sum_excl[7:4]})
                || (judge_i.tail[4] != {CHAR_BASE, judge_i.sum_excl[3:0]});

        if (too_short || judge_i.tail[0] != ENQ_BYTE) begin
            err_o = ERR_FRAME;
        end else if (len_bad) begin
            err_o = ERR_LENGTH;
        end else if (csum_bad) begin
            err_o = ERR_CSUM;
        end else if (judge_i.eot_byte != EOT_BYTE) begin
            err_o = ERR_FRAME;
        end else begin
            err_o = ERR_OK;
        end
    end

endmodule

// File: rtl/core/crd_tracker.sv
// ----------------------------------------------------------------------------
// crd_tracker
// frame state registers and per-byte result decision
// ----------------------------------------------------------------------------
module crd_tracker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance_i,
    input  logic [7:0]           byte_i,
    output logic                 res_valid_o,
    output crd_pkg::crd_result_t res_o
);
    import crd_pkg::*;

    logic        in_frame_reg,  in_frame_next;
    crd_judge_t  judge_reg,     judge_next;
    logic [47:0] status_reg,    status_next;

    err_t        err;
    logic [7:0]  idx;
    logic [7:0]  len_cur;
    logic        long_enough;

    crd_check u_check (
        .judge_i (judge_reg),
        .err_o   (err)
    );

    always_comb begin
        in_frame_next = in_frame_reg;
        judge_next    = judge_reg;
        status_next   = status_reg;
        res_valid_o   = 1'b0;
        res_o         = '0;
        idx           = judge_reg.body_count;
        len_cur       = (idx == 8'd0) ? (byte_i - LEN_OFFSET) : judge_reg.declared_length;
        long_enough   = (len_cur >= MIN_LENGTH);

        if (!in_frame_reg) begin
            if (byte_i == SOH_BYTE) begin
                in_frame_next = 1'b1;
                judge_next    = '0;
                status_next   = '0;
            end
        end else if (byte_i == ETX_BYTE) begin
            res_valid_o       = 1'b1;
            res_o.item_kind   = KIND_VERDICT;
            res_o.error_code  = err;
            res_o.status_word = (err == ERR_OK) ? status_reg : 48'd0;
            res_o.is_last     = 1'b1;
            in_frame_next     = 1'b0;
        end else begin
            // checksum window moves on every body byte
            judge_next.sum_excl = judge_reg.sum_excl + {8'd0, judge_reg.tail[1]};
            for (int k = 0; k < TAIL_N - 1; k++) begin
                judge_next.tail[k] = judge_reg.tail[k+1];
            end
            judge_next.tail[TAIL_N-1] = byte_i;

            if (!judge_reg.overflow) begin
                if (idx == 8'd0) begin
                    judge_next.declared_length = len_cur;
                end
                if (&judge_reg.body_count) begin
                    judge_next.overflow = 1'b1;
                end else begin
                    judge_next.body_count = judge_reg.body_count + 8'd1;
                end
                if (long_enough) begin
                    if (idx == len_cur - EOT_OFS) begin
                        judge_next.eot_byte = byte_i;
                    end
                    if (idx >= len_cur - STATUS_FIRST_OFS && idx <= len_cur - STATUS_LAST_OFS) begin
                        status_next = {status_reg[39:0], byte_i};
                    end
                end
                if (len_cur >= MIN_PAYLOAD_LEN && idx >= PAYLOAD_FIRST_IDX
                    && idx <= len_cur - PAYLOAD_LAST_OFS) begin
                    res_valid_o        = 1'b1;
                    res_o.item_kind    = KIND_PAYLOAD;
                    res_o.payload_byte = byte_i;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            judge_reg    <= '0;
            status_reg   <= '0;
        end else if (advance_i) begin
            in_frame_reg <= in_frame_next;
            judge_reg    <= judge_next;
            status_reg   <= status_next;
        end
    end

endmodule

// File: rtl/core/cash_register_reply_deframer.sv
// ----------------------------------------------------------------------------
// cash_register_reply_deframer
// streaming deframer for fiscal printer reply frames, one byte per request
// ----------------------------------------------------------------------------
// Takes one received byte per input request and sustains one byte per clock
// while the master side takes results. Each byte is taken into an input
// register and, when the result register is free or draining, its result
// is loaded there and offered to the master; the rate is set by the single
// frame tracker stage, which updates the frame state once per byte. A held
// result that is not taken stalls the input register, and the input then
// stalls once that register is full. Bytes outside a frame are dropped until
// SOH. Inside a frame, payload bytes come out as they arrive (tuser 0) and
// ETX yields one verdict (tuser 1, tlast 1) carrying the error code and, on
// success only, the 48-bit status word. The payload is emitted speculatively:
// drop it when the verdict is not ok.
// ----------------------------------------------------------------------------
module cash_register_reply_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] payload_byte, [9:8] error_code,
                                   // [57:10] status_word, [63:58] zero
    output logic        m_tuser,   // [0] item_kind
    output logic        m_tlast    // is_last
);
    import crd_pkg::*;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    // result register
    logic        out_valid_reg;
    crd_result_t out_reg;

    logic        advance;
    logic        res_valid;
    crd_result_t res;

    // the held byte moves on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // frame state and per-byte decision
    crd_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance_i   (advance),
        .byte_i      (in_byte_reg),
        .res_valid_o (res_valid),
        .res_o       (res)
    );

    // result register, loads only bytes that produce a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.status_word, out_reg.error_code, out_reg.payload_byte};
    assign m_tuser  = out_reg.item_kind;
    assign m_tlast  = out_reg.is_last;

    // only a verdict closes a frame
    a_last_on_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_VERDICT)))
        else $error("tlast does not match verdict kind");

    // payload requests carry no code and no status
    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_PAYLOAD) |-> (m_tdata[57:8] == 50'd0))
        else $error("payload request carries verdict fields");

    // status is shown on an ok verdict only
    a_status_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_VERDICT && m_tdata[9:8] != ERR_OK)
        |-> (m_tdata[57:10] == 48'd0))
        else $error("status shown on failed verdict");

    // a verdict request never carries a payload byte
    a_verdict_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_VERDICT) |-> (m_tdata[7:0] == 8'd0))
        else $error("verdict carries a payload byte");

endmodule
